FILE: design/tt_pkg.sv
// ----------------------------------------------------------------------------
// tt_pkg: shared types and constants for the tick timer table
// Beat payloads, opcodes, result kinds, sequencer states and the control
// and status bundles that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package tt_pkg;

   localparam int NUM_TIMERS_DEF = 32;

   localparam int OP_W   = 3;
   localparam int SLOT_W = 5;
   localparam int TAG_W  = 8;
   localparam int CNT_W  = 32;
   localparam int KIND_W = 2;

   localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
   localparam logic [OP_W-1:0] OP_FREE    = 3'd1;
   localparam logic [OP_W-1:0] OP_SET_TAG = 3'd2;
   localparam logic [OP_W-1:0] OP_START   = 3'd3;
   localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

   localparam logic [KIND_W-1:0] KIND_GRANT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FAIL    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [SLOT_W-1:0] slot;
      logic [TAG_W-1:0]  tag;
      logic [CNT_W-1:0]  delay;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] result_kind;
      logic [SLOT_W-1:0] result_slot;
      logic [TAG_W-1:0]  expired_tag;
      logic              last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_TREAD,
      ST_TCHECK,
      ST_TFLUSH
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_mode_type;

   typedef struct packed {
      logic         ready;
      logic         rd_en;
      logic         alloc_grant;
      logic         alloc_fail;
      logic         hit_take;
      logic         push_mid;
      logic         push_last;
      alu_mode_type mode;
   } ctl_type;

   typedef struct packed {
      logic is_free;
      logic hit;
      logic pend_valid;
      logic out_free;
   } sts_type;

endpackage

FILE: design/tt_ram.sv
// ----------------------------------------------------------------------------
// tt_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tt_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/tt_alu.sv
// ----------------------------------------------------------------------------
// tt_alu: shared 32-bit adder / comparator
// Adds for deadline computation, subtracts for the expiry compare;
// carry out set on subtract means a >= b.
// ----------------------------------------------------------------------------
module tt_alu (
   input  tt_pkg::alu_mode_type          mode,
   input  logic [tt_pkg::CNT_W-1:0]      a,
   input  logic [tt_pkg::CNT_W-1:0]      b,
   output logic [tt_pkg::CNT_W-1:0]      sum,
   output logic                          carry
);
   import tt_pkg::*;

   logic [CNT_W-1:0] b_op;
   logic             cin;

   always_comb begin
      b_op = (mode == ALU_SUB) ? ~b : b;
      cin  = (mode == ALU_SUB);
      {carry, sum} = {1'b0, a} + {1'b0, b_op} + {{CNT_W{1'b0}}, cin};
   end

endmodule

FILE: design/tt_ctrl.sv
// ----------------------------------------------------------------------------
// tt_ctrl: scan sequencer
// Walks the slot index one step at a time for alloc and tick, holding the
// scan while it has a beat that the result register cannot yet take.
// ----------------------------------------------------------------------------
module tt_ctrl #(
   parameter int NUM_TIMERS = tt_pkg::NUM_TIMERS_DEF,
   parameter int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_fire,
   input  logic [tt_pkg::OP_W-1:0] req_opcode,
   input  tt_pkg::sts_type         sts,
   output tt_pkg::ctl_type         ctl,
   output logic [IDX_W-1:0]        scan_idx
);
   import tt_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             at_last;

   assign at_last  = (idx_ff == LAST_IDX);
   assign scan_idx = idx_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_fire) begin
               if (req_opcode == OP_ALLOC) begin
                  state_in = ST_ALLOC;
               end else if (req_opcode == OP_TICK) begin
                  state_in = ST_TREAD;
               end
            end
         end
         ST_ALLOC: begin
            if (sts.is_free || at_last) begin
               if (sts.out_free) begin
                  state_in = ST_IDLE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_TREAD: begin
            state_in = ST_TCHECK;
         end
         ST_TCHECK: begin
            if (!(sts.hit && sts.pend_valid && !sts.out_free)) begin
               if (at_last) begin
                  state_in = ST_TFLUSH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_TREAD;
               end
            end
         end
         ST_TFLUSH: begin
            if (!sts.pend_valid || sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl             = '0;
      ctl.mode        = ALU_ADD;
      ctl.ready       = (state_ff == ST_IDLE);
      ctl.rd_en       = (state_ff == ST_TREAD);
      ctl.alloc_grant = (state_ff == ST_ALLOC) && sts.is_free && sts.out_free;
      ctl.alloc_fail  = (state_ff == ST_ALLOC) && !sts.is_free && at_last && sts.out_free;
      ctl.hit_take    = (state_ff == ST_TCHECK) && sts.hit
                        && (!sts.pend_valid || sts.out_free);
      ctl.push_mid    = ctl.hit_take && sts.pend_valid;
      ctl.push_last   = (state_ff == ST_TFLUSH) && sts.pend_valid && sts.out_free;
      if (state_ff == ST_TCHECK) begin
         ctl.mode = ALU_SUB;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

FILE: design/tick_timer_table_unit.sv
// ----------------------------------------------------------------------------
// tick_timer_table_unit: table of software timers driven by opcode beats
// Free, set tag and start update the table when accepted. Alloc scans one
// slot per cycle, holding on the slot it grants or fails at until the result
// register is free. Tick reads, then checks, each slot in turn through the
// shared comparator, holding while an expiry waits on a stalled result side.
// Reset clears the slot status and the tick count; deadline and tag RAMs are undefined until written.
// ----------------------------------------------------------------------------
module tick_timer_table_unit #(
   parameter int NUM_TIMERS = tt_pkg::NUM_TIMERS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  tt_pkg::req_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output tt_pkg::rsp_type rsp_payload
);
   import tt_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   ctl_type          ctl;
   sts_type          sts;
   logic [IDX_W-1:0] scan_idx;
   logic [IDX_W-1:0] slot_idx;
   logic             req_fire;
   logic             in_range;

   logic [NUM_TIMERS-1:0] alloc_ff, alloc_in;
   logic [NUM_TIMERS-1:0] armed_ff, armed_in;
   logic [CNT_W-1:0]      tick_count_ff, tick_count_in;

   logic             pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0] pend_slot_ff, pend_slot_in;
   logic [TAG_W-1:0] pend_tag_ff, pend_tag_in;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    out_load;

   logic [CNT_W-1:0] dl_rd;
   logic [TAG_W-1:0] tag_rd;
   logic [CNT_W-1:0] alu_b;
   logic [CNT_W-1:0] alu_sum;
   logic             alu_carry;

   assign req_ready = ctl.ready;
   assign req_fire  = req_valid && ctl.ready;
   assign in_range  = int'(req_payload.slot) < NUM_TIMERS;
   assign slot_idx  = IDX_W'(req_payload.slot);

   assign sts.is_free    = !alloc_ff[scan_idx];
   assign sts.hit        = armed_ff[scan_idx] && alu_carry;
   assign sts.pend_valid = pend_valid_ff;
   assign sts.out_free   = !out_valid_ff || rsp_ready;

   tt_ctrl #(
      .NUM_TIMERS (NUM_TIMERS),
      .IDX_W      (IDX_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .req_opcode (req_payload.opcode),
      .sts        (sts),
      .ctl        (ctl),
      .scan_idx   (scan_idx)
   );

   assign alu_b = (ctl.mode == ALU_SUB) ? dl_rd : req_payload.delay;

   tt_alu u_alu (
      .mode  (ctl.mode),
      .a     (tick_count_ff),
      .b     (alu_b),
      .sum   (alu_sum),
      .carry (alu_carry)
   );

   tt_ram #(
      .WIDTH  (CNT_W),
      .DEPTH  (NUM_TIMERS),
      .ADDR_W (IDX_W)
   ) u_deadline_ram (
      .clock   (clock),
      .wr_en   (req_fire && (req_payload.opcode == OP_START) && in_range),
      .wr_addr (slot_idx),
      .wr_data (alu_sum),
      .rd_en   (ctl.rd_en),
      .rd_addr (scan_idx),
      .rd_data (dl_rd)
   );

   tt_ram #(
      .WIDTH  (TAG_W),
      .DEPTH  (NUM_TIMERS),
      .ADDR_W (IDX_W)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (req_fire && (req_payload.opcode == OP_SET_TAG) && in_range),
      .wr_addr (slot_idx),
      .wr_data (req_payload.tag),
      .rd_en   (ctl.rd_en),
      .rd_addr (scan_idx),
      .rd_data (tag_rd)
   );

   // slot status: free = neither bit, allocated = alloc only, armed = both
   always_comb begin
      alloc_in      = alloc_ff;
      armed_in      = armed_ff;
      tick_count_in = tick_count_ff;
      if (req_fire) begin
         case (req_payload.opcode)
            OP_FREE: begin
               if (in_range) begin
                  alloc_in[slot_idx] = 1'b0;
                  armed_in[slot_idx] = 1'b0;
               end
            end
            OP_START: begin
               if (in_range) begin
                  alloc_in[slot_idx] = 1'b1;
                  armed_in[slot_idx] = 1'b1;
               end
            end
            OP_TICK: begin
               tick_count_in = tick_count_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end
      if (ctl.alloc_grant) begin
         alloc_in[scan_idx] = 1'b1;
      end
      if (ctl.hit_take) begin
         armed_in[scan_idx] = 1'b0;
      end
   end

   // one expiry held back so the final beat of a tick can carry last
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_tag_in   = pend_tag_ff;
      if (ctl.hit_take) begin
         pend_valid_in = 1'b1;
         pend_slot_in  = scan_idx;
         pend_tag_in   = tag_rd;
      end else if (ctl.push_last) begin
         pend_valid_in = 1'b0;
      end
   end

   assign out_load = ctl.alloc_grant || ctl.alloc_fail || ctl.push_mid || ctl.push_last;

   always_comb begin
      out_data_in = out_data_ff;
      if (ctl.alloc_grant) begin
         out_data_in.result_kind = KIND_GRANT;
         out_data_in.result_slot = SLOT_W'(scan_idx);
         out_data_in.expired_tag = '0;
         out_data_in.last        = 1'b1;
      end else if (ctl.alloc_fail) begin
         out_data_in.result_kind = KIND_FAIL;
         out_data_in.result_slot = '0;
         out_data_in.expired_tag = '0;
         out_data_in.last        = 1'b1;
      end else if (ctl.push_mid || ctl.push_last) begin
         out_data_in.result_kind = KIND_EXPIRED;
         out_data_in.result_slot = SLOT_W'(pend_slot_ff);
         out_data_in.expired_tag = pend_tag_ff;
         out_data_in.last        = ctl.push_last;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff      <= '0;
         armed_ff      <= '0;
         tick_count_ff <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         alloc_ff      <= alloc_in;
         armed_ff      <= armed_in;
         tick_count_ff <= tick_count_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_slot_ff <= pend_slot_in;
      pend_tag_ff  <= pend_tag_in;
      out_data_ff  <= out_data_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   a_armed_is_alloc: assert property (@(posedge clock) disable iff (reset)
      (armed_ff & ~alloc_ff) == '0)
      else $error("armed slot not marked allocated");

   a_pend_only_in_tick: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> !req_ready)
      else $error("held expiry outside a tick scan");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten");

   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_payload.opcode == OP_TICK))
      |=> (tick_count_ff == $past(tick_count_ff) + 32'd1))
      else $error("tick count did not advance");

endmodule

FILE: tb/tick_timer_table_unit_tb.sv
// ----------------------------------------------------------------------------
// tick_timer_table_unit_tb: self-checking bench for the tick timer table
// A short directed table covers alloc grant, free, tag writes, start with
// delay extremes and deadline wrap, disarm, retag and unused opcodes; an
// alloc failure, a tick that expires every slot and random beats follow.
// Every result is checked in order against an in-bench timer table model,
// with random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tick_timer_table_unit_tb;
   import tt_pkg::*;

   localparam int NTIM        = tt_pkg::NUM_TIMERS_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RAND_BEATS  = 250;
   localparam rsp_type NO_RSP = '0;

   typedef enum logic [1:0] {
      SLOT_FREE,
      SLOT_HELD,
      SLOT_ARMED
   } slot_state_type;

   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   slot_state_type   slot_st [NTIM];
   logic [CNT_W-1:0] due_tick [NTIM];
   logic [TAG_W-1:0] tag_mem [NTIM];
   bit               tag_set [NTIM];
   logic [CNT_W-1:0] tick_now;

   rsp_type     timer_events [$];
   dir_row_type dir_rows [$];
   int          errors = 0;
   int          cycle_count = 0;
   bit          no_idle = 1'b0;

   tick_timer_table_unit #(.NUM_TIMERS(NTIM)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic req_type mk_req(logic [OP_W-1:0] op, int s, int tg, logic [CNT_W-1:0] dl);
      req_type b;
      b.opcode = op;
      b.slot   = s[SLOT_W-1:0];
      b.tag    = tg[TAG_W-1:0];
      b.delay  = dl;
      return b;
   endfunction

   function automatic rsp_type mk_rsp(logic [KIND_W-1:0] k, int s, int tg, logic l);
      rsp_type r;
      r.result_kind = k;
      r.result_slot = s[SLOT_W-1:0];
      r.expired_tag = tg[TAG_W-1:0];
      r.last        = l;
      return r;
   endfunction

   function automatic int idle_draw();
      if (no_idle)
         return 0;
      return $urandom_range(0, 11);
   endfunction

   // timer table model: updates state, queues the results of one beat
   function automatic void apply_timer_op(req_type b);
      int      i;
      int      hits;
      rsp_type r;
      rsp_type held;
      hits = 0;
      case (b.opcode)
         OP_ALLOC: begin
            r = mk_rsp(KIND_FAIL, 0, 0, 1'b1);
            for (i = 0; i < NTIM; i++) begin
               if (r.result_kind == KIND_FAIL && slot_st[i] == SLOT_FREE) begin
                  slot_st[i] = SLOT_HELD;
                  r = mk_rsp(KIND_GRANT, i, 0, 1'b1);
               end
            end
            timer_events.push_back(r);
         end
         OP_FREE: begin
            if (b.slot < NTIM)
               slot_st[b.slot] = SLOT_FREE;
         end
         OP_SET_TAG: begin
            if (b.slot < NTIM) begin
               tag_mem[b.slot] = b.tag;
               tag_set[b.slot] = 1'b1;
            end
         end
         OP_START: begin
            if (b.slot < NTIM) begin
               due_tick[b.slot] = b.delay + tick_now;
               slot_st[b.slot]  = SLOT_ARMED;
            end
         end
         OP_TICK: begin
            tick_now = tick_now + 1'b1;
            for (i = 0; i < NTIM; i++) begin
               if (slot_st[i] == SLOT_ARMED && due_tick[i] <= tick_now) begin
                  slot_st[i] = SLOT_HELD;
                  if (hits > 0)
                     timer_events.push_back(held);
                  held = mk_rsp(KIND_EXPIRED, i, tag_mem[i], 1'b0);
                  hits++;
               end
            end
            if (hits > 0) begin
               held.last = 1'b1;
               timer_events.push_back(held);
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic int pick_slot();
      int cand [$];
      int i;
      for (i = 0; i < NTIM; i++)
         if (slot_st[i] != SLOT_FREE)
            cand.push_back(i);
      if (cand.size() > 0 && $urandom_range(0, 3) != 0)
         return cand[$urandom_range(0, cand.size() - 1)];
      return $urandom_range(0, NTIM - 1);
   endfunction

   task automatic send_beat(req_type b, bit typed, rsp_type want);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= b;
      do @(posedge clock); while (!req_ready);
      apply_timer_op(b);
      if (typed) begin
         void'(timer_events.pop_back());
         timer_events.push_back(want);
      end
   endtask

   // result side
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = idle_draw();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (timer_events.size() == 0) begin
            $display("%0t: result beat with none due: kind %0d slot %0d tag %02h last %0d",
                     $time, rsp_payload.result_kind, rsp_payload.result_slot,
                     rsp_payload.expired_tag, rsp_payload.last);
            errors++;
         end else begin
            exp_r = timer_events.pop_front();
            if (rsp_payload !== exp_r) begin
               $display("%0t: mismatch: expected kind %0d slot %0d tag %02h last %0d,",
                        $time, exp_r.result_kind, exp_r.result_slot, exp_r.expired_tag,
                        exp_r.last,
                        " actual kind %0d slot %0d tag %02h last %0d",
                        rsp_payload.result_kind, rsp_payload.result_slot,
                        rsp_payload.expired_tag, rsp_payload.last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int      i;
      int      n;
      int      phase;
      int      pick;
      req_type b;
      req_type pre;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      for (i = 0; i < NTIM; i++) begin
         slot_st[i] = SLOT_FREE;
         tag_set[i] = 1'b0;
      end
      tick_now = '0;

      dir_rows.push_back('{mk_req(OP_ALLOC, 0, 0, 0), 1'b1, mk_rsp(KIND_GRANT, 0, 0, 1'b1)});
      dir_rows.push_back('{mk_req(OP_ALLOC, 0, 0, 0), 1'b1, mk_rsp(KIND_GRANT, 1, 0, 1'b1)});
      dir_rows.push_back('{mk_req(OP_SET_TAG, 0, 8'hFF, 0), 1'b0, NO_RSP});
      dir_rows.push_back('{mk_req(OP_SET_TAG, 1, 8'h00, 0), 1'b0, NO_RSP});
      dir_rows.push_back('{mk_req(OP_START, 0, 0, 32'h0), 1'b0, NO_RSP});
      dir_rows.push_back('{mk_req(OP_START, 1, 0, 32'hFFFF_FFFF), 1'b0, NO_RSP});
      dir_rows.push_back('{mk_req(OP_TICK, 0, 0, 0), 1'b1, mk_rsp(KIND_EXPIRED, 0, 8'hFF, 1'b1)});
      dir_rows.push_back('{mk_req(OP_TICK, 0, 0, 0), 1'b0, NO_RSP});
      dir_rows.push_back('{mk_req(OP_SET_TAG, 31, 8'hA5, 0), 1'b0, NO_RSP});
      // start on a free slot arms it
      dir_rows.push_back('{mk_req(OP_START, 31, 0, 32'd1), 1'b0, NO_RSP});
      dir_rows.push_back('{mk_req(3'd5, $urandom_range(0, 31), $urandom_range(0, 255), $urandom),
                           1'b0, NO_RSP});
      dir_rows.push_back('{mk_req(3'd6, $urandom_range(0, 31), $urandom_range(0, 255), $urandom),
                           1'b0, NO_RSP});
      dir_rows.push_back('{mk_req(3'd7, 31, 8'hFF, 32'hFFFF_FFFF), 1'b0, NO_RSP});
      dir_rows.push_back('{mk_req(OP_FREE, 1, 0, 0), 1'b0, NO_RSP});
      dir_rows.push_back('{mk_req(OP_TICK, 0, 0, 0), 1'b0, NO_RSP});
      dir_rows.push_back('{mk_req(OP_ALLOC, 0, 0, 0), 1'b0, NO_RSP});
      dir_rows.push_back('{mk_req(OP_SET_TAG, 1, 8'h5A, 0), 1'b0, NO_RSP});
      // deadline wraps below the current count
      dir_rows.push_back('{mk_req(OP_START, 1, 0, 32'hFFFF_FFFF), 1'b0, NO_RSP});
      dir_rows.push_back('{mk_req(OP_SET_TAG, 1, 8'hC3, 0), 1'b0, NO_RSP});
      dir_rows.push_back('{mk_req(OP_START, 0, 0, 32'd2), 1'b0, NO_RSP});
      dir_rows.push_back('{mk_req(OP_TICK, 0, 0, 0), 1'b0, NO_RSP});
      dir_rows.push_back('{mk_req(OP_TICK, 0, 0, 0), 1'b0, NO_RSP});
      dir_rows.push_back('{mk_req(OP_START, 31, 0, 32'h0), 1'b0, NO_RSP});
      dir_rows.push_back('{mk_req(OP_TICK, 0, 0, 0), 1'b0, NO_RSP});

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[n])
         send_beat(dir_rows[n].beat, dir_rows[n].typed, dir_rows[n].want);

      // fill the remaining free slots, then one alloc that must fail
      for (i = 0; i < NTIM - 3; i++)
         send_beat(mk_req(OP_ALLOC, $urandom_range(0, 31), $urandom_range(0, 255), $urandom),
                   1'b0, NO_RSP);
      send_beat(mk_req(OP_ALLOC, 0, 0, 0), 1'b1, mk_rsp(KIND_FAIL, 0, 0, 1'b1));

      req_valid <= 1'b0;
      while (timer_events.size() != 0) @(posedge clock);

      // arm every slot for the same tick
      for (i = 0; i < NTIM; i++) begin
         send_beat(mk_req(OP_SET_TAG, i, $urandom_range(0, 255), 0), 1'b0, NO_RSP);
         send_beat(mk_req(OP_START, i, 0, 32'd1), 1'b0, NO_RSP);
      end
      send_beat(mk_req(OP_TICK, 0, 0, 0), 1'b0, NO_RSP);

      for (phase = 0; phase < 5; phase++) begin
         no_idle = (phase == 1 || phase == 3);
         for (n = 0; n < RAND_BEATS / 5; n++) begin
            b.slot  = SLOT_W'(pick_slot());
            b.tag   = TAG_W'($urandom_range(0, 255));
            case ($urandom_range(0, 9))
               0:       b.delay = '0;
               1:       b.delay = '1;
               2, 3:    b.delay = $urandom;
               default: b.delay = $urandom_range(0, 6);
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 15)
               b.opcode = OP_ALLOC;
            else if (pick < 30)
               b.opcode = OP_FREE;
            else if (pick < 45)
               b.opcode = OP_SET_TAG;
            else if (pick < 70)
               b.opcode = OP_START;
            else if (pick < 95)
               b.opcode = OP_TICK;
            else
               b.opcode = OP_W'($urandom_range(5, 7));
            if (b.opcode == OP_START && !tag_set[b.slot]) begin
               pre        = b;
               pre.opcode = OP_SET_TAG;
               send_beat(pre, 1'b0, NO_RSP);
            end
            send_beat(b, 1'b0, NO_RSP);
         end
      end
      no_idle = 1'b0;

      req_valid <= 1'b0;
      while (timer_events.size() != 0) @(posedge clock);
      repeat (2 * NTIM + 8) @(posedge clock);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: files.f
design/tt_pkg.sv
design/tt_ram.sv
design/tt_alu.sv
design/tt_ctrl.sv
design/tick_timer_table_unit.sv
tb/tick_timer_table_unit_tb.sv
